[src/b64e_pkg.sv]
// b64e_pkg: shared types, constants and the alphabet lookup for the base64 encoder.
// No dependencies; used by every module of the encoder.
`timescale 1ns / 1ps

package b64e_pkg;

   // Input beat: one message byte and its end-of-message flag
   typedef struct packed {
      logic [7:0] data_byte;
      logic       final_byte;
   } b64e_req_type;

   // Output beat: one ASCII character and its end-of-message flag
   typedef struct packed {
      logic [6:0] out_char;
      logic       out_last;
   } b64e_rsp_type;

   // Position of the next byte within its 3-byte group
   typedef enum logic [1:0] {
      PHASE_0 = 2'd0,
      PHASE_1 = 2'd1,
      PHASE_2 = 2'd2
   } b64e_phase_type;

   localparam int unsigned MaxChars  = 4;
   localparam int unsigned QueueDepth = 2;
   localparam logic [6:0]  PadChar   = 7'h3D;

   // Characters produced by one input byte
   typedef struct packed {
      logic [MaxChars-1:0][6:0] chars;
      logic [2:0]               n_chars;  // 1 to 4
      logic                     fin;      // last character ends the message
   } b64e_entry_type;

   // Queue head as seen by the back end
   typedef struct packed {
      logic           valid;
      b64e_entry_type entry;
   } b64e_head_type;

   // Map a 6-bit sextet to its ASCII symbol
   function automatic logic [6:0] b64_sym(input logic [5:0] idx);
      logic [6:0] ch;
      if (idx < 6'd26) begin
         ch = 7'h41 + {1'b0, idx};
      end else if (idx < 6'd52) begin
         ch = 7'h61 + {1'b0, idx - 6'd26};
      end else if (idx < 6'd62) begin
         ch = 7'h30 + {1'b0, idx - 6'd52};
      end else if (idx == 6'd62) begin
         ch = 7'h2B;
      end else begin
         ch = 7'h2F;
      end
      return ch;
   endfunction

endpackage

[src/b64e_front.sv]
// b64e_front: accepts message bytes, tracks the group phase and leftover bits,
// and builds the character entry for each byte. Depends on b64e_pkg.
`timescale 1ns / 1ps

module b64e_front import b64e_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  b64e_req_type   req_data,
   input  logic           q_full,
   output logic           push,
   output b64e_entry_type push_entry
);

   b64e_phase_type phase_ff, phase_in;
   logic [3:0]     carry_ff, carry_in;
   logic [7:0]     d;
   logic           fin;

   assign d         = req_data.data_byte;
   assign fin       = req_data.final_byte;
   assign req_ready = !q_full;
   assign push      = req_valid && !q_full;

   // Next phase and leftover bits
   always_comb begin
      phase_in = phase_ff;
      carry_in = carry_ff;
      if (push) begin
         case (phase_ff)
            PHASE_1: begin
               phase_in = PHASE_2;
               carry_in = d[3:0];
            end
            PHASE_2: begin
               phase_in = PHASE_0;
               carry_in = 4'd0;
            end
            default: begin
               phase_in = PHASE_1;
               carry_in = {2'b00, d[1:0]};
            end
         endcase
         if (fin) begin
            phase_in = PHASE_0;
            carry_in = 4'd0;
         end
      end
   end

   // Characters produced by the current byte
   always_comb begin
      push_entry.chars   = {MaxChars{PadChar}};
      push_entry.n_chars = 3'd1;
      push_entry.fin     = fin;
      case (phase_ff)
         PHASE_1: begin
            push_entry.chars[0] = b64_sym({carry_ff[1:0], d[7:4]});
            if (fin) begin
               push_entry.chars[1] = b64_sym({d[3:0], 2'b00});
               push_entry.n_chars  = 3'd3;
            end
         end
         PHASE_2: begin
            push_entry.chars[0] = b64_sym({carry_ff[3:0], d[7:6]});
            push_entry.chars[1] = b64_sym(d[5:0]);
            push_entry.n_chars  = 3'd2;
         end
         default: begin
            push_entry.chars[0] = b64_sym(d[7:2]);
            if (fin) begin
               push_entry.chars[1] = b64_sym({d[1:0], 4'b0000});
               push_entry.n_chars  = 3'd4;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_0;
         carry_ff <= 4'd0;
      end else begin
         phase_ff <= phase_in;
         carry_ff <= carry_in;
      end
   end

endmodule

[src/b64e_queue.sv]
// b64e_queue: two-entry queue of character entries between front and back end.
// Depends on b64e_pkg.
`timescale 1ns / 1ps

module b64e_queue import b64e_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  b64e_entry_type push_entry,
   input  logic           pop,
   output logic           q_full,
   output b64e_head_type  head
);

   b64e_entry_type entries_ff [QueueDepth];
   logic           wr_ptr_ff, wr_ptr_in;
   logic           rd_ptr_ff, rd_ptr_in;
   logic [1:0]     count_ff, count_in;

   assign q_full     = (count_ff == 2'(QueueDepth));
   assign head.valid = (count_ff != 2'd0);
   assign head.entry = entries_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed entry
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

[src/b64e_back.sv]
// b64e_back: walks the queue head into the output register, one character per cycle unless rsp_ready stalls it.
// Depends on b64e_pkg.
`timescale 1ns / 1ps

module b64e_back import b64e_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  b64e_head_type head,
   output logic          pop,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output b64e_rsp_type  rsp_data
);

   logic [1:0]   idx_ff, idx_in;
   logic         rsp_valid_ff, rsp_valid_in;
   b64e_rsp_type rsp_data_ff;
   logic         load;
   logic         at_end;

   // Load a new beat when the output register is empty or being taken
   assign load   = head.valid && (!rsp_valid_ff || rsp_ready);
   assign at_end = ({1'b0, idx_ff} + 3'd1) == head.entry.n_chars;
   assign pop    = load && at_end;

   always_comb begin
      idx_in = idx_ff;
      if (load) begin
         idx_in = at_end ? 2'd0 : idx_ff + 2'd1;
      end
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the character on the output until taken
   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff.out_char <= head.entry.chars[idx_ff];
         rsp_data_ff.out_last <= head.entry.fin && at_end;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[src/base64_stream_encoder.sv]
// base64_stream_encoder: top level of the streaming base64 encoder.
// Depends on b64e_pkg, b64e_front, b64e_queue and b64e_back.
`timescale 1ns / 1ps

// Encodes a byte stream into standard base64 characters (A-Z a-z 0-9 + /, '=' pad),
// one byte per req beat with final_byte marking the end of a message, one character
// per rsp beat with out_last on the message's final character. A byte yields one or
// two characters, and a final byte yields two to four including padding. The output
// port moves one character per cycle while rsp_ready holds; as three bytes make four
// characters, the input is held back on a long message. A byte is accepted whenever
// the two-entry queue between the byte front end and the character back end has
// room; the back end's one-character output register sets the throughput. A byte is
// written into the queue and its first character then loaded into the output register.

module base64_stream_encoder import b64e_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  b64e_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output b64e_rsp_type rsp_data
);

   logic           q_full;
   logic           push;
   logic           pop;
   b64e_entry_type push_entry;
   b64e_head_type  head;

   b64e_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .q_full     (q_full),
      .push       (push),
      .push_entry (push_entry)
   );

   b64e_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .q_full     (q_full),
      .head       (head)
   );

   b64e_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // Never push into a full queue
   assert property (@(posedge clock) disable iff (reset) push |-> !q_full)
      else $error("push into full queue");

   // Every queued entry carries one to four characters
   assert property (@(posedge clock) disable iff (reset)
      head.valid |-> (head.entry.n_chars != 3'd0 && head.entry.n_chars <= 3'd4))
      else $error("bad character count in queue entry");

   // No beat appears without a queued entry behind it
   assert property (@(posedge clock) disable iff (reset)
      (!head.valid && !rsp_valid) |=> !rsp_valid)
      else $error("output beat without queued entry");

   // Output register is empty after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("output valid after reset");

endmodule

[tb/base64_stream_encoder_test.sv]
// base64_stream_encoder_test: self-checking bench for the streaming base64 encoder.
// Depends on b64e_pkg and base64_stream_encoder; an encoder class predicts every character.
`timescale 1ns / 1ps

module base64_stream_encoder_test;
   import b64e_pkg::*;

   localparam int unsigned CycleLimit   = 500000;
   localparam int unsigned RandomBytes  = 320;
   localparam int unsigned DirectedMsgs = 9;

   // Directed messages: all-zero and all-one bytes, finals in every group position,
   // the two top alphabet symbols, and carries that cross group boundaries
   localparam logic [7:0] DirectedBytes [24] = '{
      8'h00,
      8'hFF,
      8'h00, 8'hFF,
      8'hFF, 8'h00,
      8'hFF, 8'hFF, 8'hFF,
      8'h00, 8'h00, 8'h00,
      8'hFB, 8'hEF, 8'hBE,
      8'h4D, 8'h61, 8'h6E, 8'h01,
      8'h80, 8'h7F, 8'h55, 8'hAA, 8'h3C
   };
   localparam int DirectedLengths [DirectedMsgs] = '{1, 1, 2, 2, 3, 3, 3, 4, 5};

   // Predict the characters of each byte and check the encoder output against them
   class base64_char_checker;
      b64e_phase_type group_pos;
      logic [3:0]     leftover;
      b64e_rsp_type   pending_chars[$];
      string          alphabet;
      int             mismatch_count;
      int             chars_checked;
      int             bytes_noted;
      int             messages_noted;

      function new();
         group_pos      = PHASE_0;
         leftover       = '0;
         alphabet       = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
         mismatch_count = 0;
         chars_checked  = 0;
         bytes_noted    = 0;
         messages_noted = 0;
      endfunction

      function logic [6:0] sextet_char(logic [5:0] sextet);
         logic [7:0] code;
         code = alphabet[sextet];
         return code[6:0];
      endfunction

      function void push_char(logic [6:0] ch, logic last);
         b64e_rsp_type beat;
         beat.out_char = ch;
         beat.out_last = last;
         pending_chars.push_back(beat);
      endfunction

      // Advance the group state by one accepted byte and queue its characters
      function void note_byte(b64e_req_type beat);
         logic [7:0] d;
         logic       fin;
         d   = beat.data_byte;
         fin = beat.final_byte;
         bytes_noted++;
         case (group_pos)
            PHASE_1: begin
               push_char(sextet_char({leftover[1:0], d[7:4]}), 1'b0);
               if (fin) begin
                  push_char(sextet_char({d[3:0], 2'b00}), 1'b0);
                  push_char(PadChar, 1'b1);
               end else begin
                  leftover  = d[3:0];
                  group_pos = PHASE_2;
               end
            end
            PHASE_2: begin
               push_char(sextet_char({leftover, d[7:6]}), 1'b0);
               push_char(sextet_char(d[5:0]), fin);
               leftover  = '0;
               group_pos = PHASE_0;
            end
            default: begin
               push_char(sextet_char(d[7:2]), 1'b0);
               if (fin) begin
                  push_char(sextet_char({d[1:0], 4'b0000}), 1'b0);
                  push_char(PadChar, 1'b0);
                  push_char(PadChar, 1'b1);
               end else begin
                  leftover  = {2'b00, d[1:0]};
                  group_pos = PHASE_1;
               end
            end
         endcase
         // A final byte always closes the group
         if (fin) begin
            group_pos = PHASE_0;
            leftover  = '0;
            messages_noted++;
         end
      endfunction

      task report_mismatch(string what, int expected, int got);
         mismatch_count++;
         $display("[%0t] mismatch on character %0d: %s expected 0x%0h, got 0x%0h",
                  $time, chars_checked, what, expected, got);
      endtask

      // Compare one output beat with the oldest expected character
      task check_char(b64e_rsp_type beat);
         b64e_rsp_type want;
         if (pending_chars.size() == 0) begin
            report_mismatch("unexpected beat, out_char", 0, beat.out_char);
         end else begin
            want = pending_chars.pop_front();
            if (beat.out_char !== want.out_char) begin
               report_mismatch("out_char", want.out_char, beat.out_char);
            end
            if (beat.out_last !== want.out_last) begin
               report_mismatch("out_last", want.out_last, beat.out_last);
            end
         end
         chars_checked++;
      endtask
   endclass

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   b64e_req_type req_data  = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   b64e_rsp_type rsp_data;

   base64_char_checker encoder_model = new();
   logic [7:0]         msg_bytes[$];
   int                 cycle_count = 0;
   int                 ready_hold  = 0;

   base64_stream_encoder dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #4 clock = ~clock;

   // Mostly no gap, often a short one, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Hold one byte on the request channel until it is accepted
   task automatic send_byte(input b64e_req_type item, input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Send msg_bytes as one message, flagging the last byte as final
   task automatic send_message(input bit steady);
      b64e_req_type item;
      for (int i = 0; i < msg_bytes.size(); i++) begin
         item.data_byte  = msg_bytes[i];
         item.final_byte = (i == msg_bytes.size() - 1);
         send_byte(item, steady ? 0 : pick_gap());
      end
   endtask

   // Note accepted bytes before checking characters on the same edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) encoder_model.note_byte(req_data);
         if (rsp_valid && rsp_ready) encoder_model.check_char(rsp_data);
      end
   end

   // Stall the response side in random stretches, sometimes not at all for a while
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (ready_hold > 0) begin
         ready_hold = ready_hold - 1;
      end else if (rsp_ready) begin
         ready_hold = pick_gap();
         if (ready_hold > 0) begin
            rsp_ready  <= 1'b0;
            ready_hold = ready_hold - 1;
         end
      end else begin
         rsp_ready  <= 1'b1;
         ready_hold = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
                                                   : $urandom_range(0, 15);
      end
   end

   // Bound the run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
         $display("Timeout after %0d cycles, %0d characters still expected",
                  cycle_count, encoder_model.pending_chars.size());
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      int offset;
      int len;
      int r;
      int sent;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed messages
      offset = 0;
      for (int m = 0; m < DirectedMsgs; m++) begin
         msg_bytes.delete();
         for (int i = 0; i < DirectedLengths[m]; i++) begin
            msg_bytes.push_back(DirectedBytes[offset + i]);
         end
         offset += DirectedLengths[m];
         send_message(m % 2 == 0);
      end

      // Random messages, mostly short with a few long ones
      sent = 0;
      while (sent < RandomBytes) begin
         r = $urandom_range(0, 99);
         if (r < 70) len = $urandom_range(1, 9);
         else if (r < 92) len = $urandom_range(10, 24);
         else len = $urandom_range(25, 48);
         msg_bytes.delete();
         for (int i = 0; i < len; i++) begin
            msg_bytes.push_back(8'($urandom_range(0, 255)));
         end
         send_message($urandom_range(0, 3) == 0);
         sent += len;
      end
      req_valid <= 1'b0;

      // Drain the output, then wait on to catch stray beats
      while (encoder_model.pending_chars.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);

      $display("Encoded %0d messages (%0d bytes) with random gaps and stalls on both sides",
               encoder_model.messages_noted, encoder_model.bytes_noted);
      $display("Checked %0d characters, %0d mismatches",
               encoder_model.chars_checked, encoder_model.mismatch_count);
      if (encoder_model.mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

[sim.f]
src/b64e_pkg.sv
src/b64e_front.sv
src/b64e_queue.sv
src/b64e_back.sv
src/base64_stream_encoder.sv
tb/base64_stream_encoder_test.sv
